// File: rtl/plist_pkg.sv
// Package for the positional list engine: action, status and operation codes,
// field widths and the default capacity. No dependencies.
package plist_pkg;

    localparam int DefCapacity = 64;
    localparam int PosW        = 7;
    localparam int ValW        = 32;
    localparam int CntOutW     = 7;

    // code 7 is unused and has no member
    typedef enum logic [2:0] {
        ACT_ADD_FRONT = 3'd0,
        ACT_APPEND    = 3'd1,
        ACT_INS_AFTER = 3'd2,
        ACT_DEL_FIRST = 3'd3,
        ACT_DEL_LAST  = 3'd4,
        ACT_DEL_AFTER = 3'd5,
        ACT_READ      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOPOS = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_ctrl;

endpackage

// File: rtl/positional_list_engine.sv
// Positional list engine top level: input register, decoder, entry store and
// result register. Depends on plist_pkg, plist_decode and plist_store.
//
// A transaction is taken on every clock edge with start high and busy low;
// busy is high only while reset is applied and until the first clock edge after it.
// Each transaction passes the input register and then the result register and
// gives one result, on the result ports for a single cycle with o_valid high;
// the receiver cannot stall. One transaction per cycle is sustained while busy is
// low: the entry registers shift, keep or load as the result register loads.
module positional_list_engine import plist_pkg::*; #(
    parameter int CAPACITY = DefCapacity
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             i_action,
    input  logic signed [ValW-1:0] i_item_value,
    input  logic [PosW-1:0]        i_position,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [CntOutW-1:0]     o_entry_count,
    output logic signed [ValW-1:0] o_entry_value
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic            r_ready;
    logic            r_go;
    logic [2:0]      r_action;
    logic [ValW-1:0] r_value;
    logic [PosW-1:0] r_pos;

    t_ctrl           w_ctrl;
    logic [IW-1:0]   w_idx;
    logic [CW-1:0]   w_count;
    logic [CW-1:0]   w_next_count;
    logic [ValW-1:0] w_rd_value;

    assign busy = !r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_go    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_go    <= start && r_ready;
            o_valid <= r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action      <= i_action;
        r_value       <= i_item_value;
        r_pos         <= i_position;
        o_status      <= w_ctrl.status;
        o_entry_count <= CntOutW'(w_next_count);
        o_entry_value <= (w_ctrl.op == OP_DEL || w_ctrl.op == OP_READ) ? w_rd_value : '0;
    end

    plist_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .i_action   (r_action),
        .i_position (r_pos),
        .i_count    (w_count),
        .o_ctrl     (w_ctrl),
        .o_idx      (w_idx)
    );

    plist_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (r_go),
        .i_ctrl       (w_ctrl),
        .i_idx        (w_idx),
        .i_value      (r_value),
        .o_count      (w_count),
        .o_next_count (w_next_count),
        .o_rd_value   (w_rd_value)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> o_entry_count == CntOutW'(CAPACITY))
        else $error("full status without a full list");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> o_entry_count == '0)
        else $error("empty status with entries present");

    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_entry_value == '0)
        else $error("non-zero value on an error result");

endmodule

// File: rtl/plist_decode.sv
// Action decoder: checks the request against the current count and yields the
// store operation, the slot index and the status. Depends on plist_pkg.
module plist_decode import plist_pkg::*; #(
    parameter int CAPACITY = DefCapacity,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic [2:0]      i_action,
    input  logic [PosW-1:0] i_position,
    input  logic [CW-1:0]   i_count,
    output t_ctrl           o_ctrl,
    output logic [IW-1:0]   o_idx
);

    localparam int MW = (CW > PosW) ? CW : PosW;

    logic [MW-1:0] w_pos;
    logic [MW-1:0] w_cnt;
    logic [MW-1:0] w_idx;
    logic          w_full;
    logic          w_empty;

    assign w_pos   = MW'(i_position);
    assign w_cnt   = MW'(i_count);
    assign w_full  = (w_cnt == MW'(CAPACITY));
    assign w_empty = (w_cnt == '0);
    assign o_idx   = w_idx[IW-1:0];

    always_comb begin
        o_ctrl.op     = OP_NONE;
        o_ctrl.status = ST_OK;
        w_idx         = '0;
        unique case (t_action'(i_action))
            ACT_ADD_FRONT: begin
                if (w_full) begin
                    o_ctrl.status = ST_FULL;
                end else begin
                    o_ctrl.op = OP_INS;
                end
            end
            ACT_APPEND: begin
                if (w_full) begin
                    o_ctrl.status = ST_FULL;
                end else begin
                    o_ctrl.op = OP_INS;
                    w_idx     = w_cnt;
                end
            end
            ACT_INS_AFTER: begin
                if (w_full) begin
                    o_ctrl.status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    o_ctrl.status = ST_NOPOS;
                end else begin
                    o_ctrl.op = OP_INS;
                    w_idx     = w_pos;
                end
            end
            ACT_DEL_FIRST: begin
                if (w_empty) begin
                    o_ctrl.status = ST_EMPTY;
                end else begin
                    o_ctrl.op = OP_DEL;
                end
            end
            ACT_DEL_LAST: begin
                if (w_empty) begin
                    o_ctrl.status = ST_EMPTY;
                end else begin
                    o_ctrl.op = OP_DEL;
                    w_idx     = w_cnt - MW'(1);
                end
            end
            ACT_DEL_AFTER: begin
                if (w_empty) begin
                    o_ctrl.status = ST_EMPTY;
                end else if (w_pos < w_cnt) begin
                    o_ctrl.op = OP_DEL;
                    w_idx     = w_pos;
                end else if (w_pos == w_cnt) begin
                    o_ctrl.op = OP_DEL;
                    w_idx     = w_cnt - MW'(1);
                end else begin
                    o_ctrl.status = ST_NOPOS;
                end
            end
            ACT_READ: begin
                if (w_empty) begin
                    o_ctrl.status = ST_EMPTY;
                end else if (w_pos != '0 && w_pos <= w_cnt) begin
                    o_ctrl.op = OP_READ;
                    w_idx     = w_pos - MW'(1);
                end else begin
                    o_ctrl.status = ST_NOPOS;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/plist_store.sv
// Entry store: a row of entry registers, each of which shifts, keeps or loads
// from an index compare, plus the entry count. Depends on plist_pkg.
module plist_store import plist_pkg::*; #(
    parameter int CAPACITY = DefCapacity,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  t_ctrl           i_ctrl,
    input  logic [IW-1:0]   i_idx,
    input  logic [ValW-1:0] i_value,
    output logic [CW-1:0]   o_count,
    output logic [CW-1:0]   o_next_count,
    output logic [ValW-1:0] o_rd_value
);

    logic [ValW-1:0] r_entries [CAPACITY];
    logic [ValW-1:0] n_entries [CAPACITY];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_count      = r_count;
    assign o_next_count = n_count;
    assign o_rd_value   = r_entries[i_idx];

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        if (i_go) begin
            case (i_ctrl.op)
                OP_INS: begin
                    for (int k = 1; k < CAPACITY; k++) begin
                        if (IW'(k) > i_idx) begin
                            n_entries[k] = r_entries[k-1];
                        end
                    end
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (IW'(k) == i_idx) begin
                            n_entries[k] = i_value;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
                OP_DEL: begin
                    for (int k = 0; k < CAPACITY - 1; k++) begin
                        if (IW'(k) >= i_idx) begin
                            n_entries[k] = r_entries[k+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
